@@ rtl/floppy_sector_record_parser_assert.svh @@
// Assertion macros shared by the floppy sector record parser RTL.
`ifndef FLOPPY_SECTOR_RECORD_PARSER_ASSERT_SVH
`define FLOPPY_SECTOR_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FSRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsrp: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FSRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsrp: next-cycle check failed");

`endif

@@ rtl/fsrp_pkg.sv @@
// Package with the types and constants of the floppy sector record parser.
`default_nettype none
package fsrp_pkg;

	localparam int MAX_SIZE_CODE_DEF = 7;
	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam int POS_W = 15;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		CFG_HEADER_LEN     = 3'd0,
		CFG_SECTOR_ID_BASE = 3'd1,
		CFG_CRC_SEED       = 3'd2,
		CFG_ID_MARK        = 3'd3,
		CFG_DATA_MARK_A    = 3'd4,
		CFG_DATA_MARK_B    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_PENDING = 2'd0,
		KIND_ID      = 2'd1,
		KIND_DATA    = 2'd2,
		KIND_IGNORED = 2'd3
	} rec_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_CRC   = 2'd1,
		STATUS_TRUNCATED = 2'd2
	} sector_status_t;

	typedef struct packed {
		logic [1:0]  header_len;
		logic [7:0]  sector_id_base;
		logic [15:0] crc_seed;
		logic [7:0]  id_mark;
		logic [7:0]  data_mark_a;
		logic [7:0]  data_mark_b;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		header_len:     2'd3,
		sector_id_base: 8'h00,
		crc_seed:       16'hFFFF,
		id_mark:        8'hFE,
		data_mark_a:    8'hFB,
		data_mark_b:    8'hF8
	};

	typedef struct packed {
		logic              item_kind;
		logic [7:0]        payload_byte;
		logic [7:0]        cylinder;
		logic [7:0]        head_side;
		logic signed [8:0] sector_number;
		logic [2:0]        size_code;
		logic [1:0]        sector_status;
		logic              last_of_sector;
	} item_t;

	typedef struct packed {
		logic [1:0] cnt;
		item_t      item0;
		item_t      item1;
	} push_t;

endpackage
`default_nettype wire

@@ rtl/fsrp_out_fifo.sv @@
// Output queue of result items, taking up to two items per cycle.
`default_nettype none
module fsrp_out_fifo (
	input  wire                              clk,
	input  wire                              arst_n,
	input  fsrp_pkg::push_t                  push,
	output logic [fsrp_pkg::OUT_CNT_W-1:0]   count,
	output logic                             out_valid,
	input  wire                              out_ready,
	output fsrp_pkg::item_t                  out_item
);

	fsrp_pkg::item_t mem_q [fsrp_pkg::OUT_DEPTH];
	logic [fsrp_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [fsrp_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [fsrp_pkg::OUT_CNT_W-1:0] count_q;
	logic [fsrp_pkg::OUT_PTR_W-1:0] wr_ptr_next;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_item = mem_q[rd_ptr_q];
	assign count = count_q;
	assign wr_ptr_next = wr_ptr_q + fsrp_pkg::OUT_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_next] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fsrp_pkg::OUT_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fsrp_pkg::OUT_PTR_W'(1);
			end
			count_q <= count_q + fsrp_pkg::OUT_CNT_W'(push.cnt)
				- fsrp_pkg::OUT_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/fsrp_parser.sv @@
// Input register, record state and CRC logic of the sector record parser.
`default_nettype none
module fsrp_parser #(
	parameter int MAX_SIZE_CODE = fsrp_pkg::MAX_SIZE_CODE_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  fsrp_pkg::cfg_t   cfg,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [7:0]       in_byte,
	input  wire              in_start,
	input  wire              in_end,
	input  wire              room,
	output fsrp_pkg::push_t  push
);

	typedef struct packed {
		logic [7:0] cylinder;
		logic [7:0] head_side;
		logic [7:0] sector;
		logic [2:0] size;
	} id_t;

	localparam logic [fsrp_pkg::POS_W-1:0] POS_MAX = '1;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ fsrp_pkg::CRC16_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic fsrp_pkg::item_t make_status(input id_t id, input logic [7:0] base,
			input fsrp_pkg::sector_status_t st);
		fsrp_pkg::item_t it;
		it = '0;
		it.item_kind      = 1'b1;
		it.cylinder       = id.cylinder;
		it.head_side      = id.head_side;
		it.sector_number  = $signed({1'b0, id.sector} - {1'b0, base});
		it.size_code      = id.size;
		it.sector_status  = st;
		it.last_of_sector = 1'b1;
		return it;
	endfunction

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;
	logic       advance;

	// Record state.
	logic                      open_q, open_d;
	logic [fsrp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [15:0]               crc_q, crc_d;
	fsrp_pkg::rec_kind_t       kind_q, kind_d;
	logic                      done_q, done_d;
	logic [15:0]               rcrc_q, rcrc_d;
	logic [31:0]               shadow_q, shadow_d;
	id_t                       comm_q, comm_d;
	logic                      idv_q, idv_d;

	logic [fsrp_pkg::POS_W-1:0] q_off;
	logic [fsrp_pkg::POS_W-1:0] body;
	logic [1:0]                n_d;
	fsrp_pkg::item_t           item0_d, item1_d;
	fsrp_pkg::item_t           new_item;
	logic                      emit;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
			end_s1   <= in_end;
		end
	end

	always_comb begin
		open_d   = open_q;
		pos_d    = pos_q;
		crc_d    = crc_q;
		kind_d   = kind_q;
		done_d   = done_q;
		rcrc_d   = rcrc_q;
		shadow_d = shadow_q;
		comm_d   = comm_q;
		idv_d    = idv_q;
		n_d      = 2'd0;
		item0_d  = '0;
		item1_d  = '0;
		q_off    = '0;
		body     = '0;
		new_item = '0;
		emit     = 1'b0;

		if (start_s1) begin
			if (open_q && kind_q == fsrp_pkg::KIND_DATA && !done_q) begin
				item0_d = make_status(comm_d, cfg.sector_id_base, fsrp_pkg::STATUS_TRUNCATED);
				n_d     = 2'd1;
				done_d  = 1'b1;
				idv_d   = 1'b0;
			end
			open_d = 1'b1;
			pos_d  = '0;
			crc_d  = cfg.crc_seed;
			kind_d = fsrp_pkg::KIND_PENDING;
			done_d = 1'b0;
			rcrc_d = '0;
		end

		if (open_d) begin
			q_off = pos_d - fsrp_pkg::POS_W'(cfg.header_len) - fsrp_pkg::POS_W'(1);
			body  = (kind_d == fsrp_pkg::KIND_ID) ? fsrp_pkg::POS_W'(4)
				: (fsrp_pkg::POS_W'(128) << comm_d.size);
			if (kind_d == fsrp_pkg::KIND_PENDING) begin
				if (pos_d < fsrp_pkg::POS_W'(cfg.header_len)) begin
					crc_d = crc_add(crc_d, byte_s1);
				end else if (pos_d == fsrp_pkg::POS_W'(cfg.header_len)) begin
					crc_d = crc_add(crc_d, byte_s1);
					if (byte_s1 == cfg.id_mark) begin
						kind_d = fsrp_pkg::KIND_ID;
					end else if ((byte_s1 == cfg.data_mark_a || byte_s1 == cfg.data_mark_b)
							&& idv_d) begin
						kind_d = fsrp_pkg::KIND_DATA;
					end else begin
						kind_d = fsrp_pkg::KIND_IGNORED;
					end
				end else begin
					kind_d = fsrp_pkg::KIND_IGNORED;
				end
			end else if (kind_d != fsrp_pkg::KIND_IGNORED
					&& pos_d > fsrp_pkg::POS_W'(cfg.header_len)) begin
				if (q_off < body) begin
					crc_d = crc_add(crc_d, byte_s1);
					if (kind_d == fsrp_pkg::KIND_ID) begin
						shadow_d = {shadow_d[23:0], byte_s1};
					end else begin
						new_item = '0;
						new_item.payload_byte = byte_s1;
						emit = 1'b1;
					end
				end else if (q_off == body) begin
					rcrc_d = {byte_s1, 8'h00};
				end else if (q_off == body + fsrp_pkg::POS_W'(1)) begin
					rcrc_d = {rcrc_d[15:8], byte_s1};
					if (kind_d == fsrp_pkg::KIND_ID) begin
						if (shadow_d[7:0] <= 8'(MAX_SIZE_CODE)) begin
							if (rcrc_d == crc_d) begin
								comm_d = '{cylinder: shadow_d[31:24], head_side: shadow_d[23:16],
									sector: shadow_d[15:8], size: shadow_d[2:0]};
								idv_d  = 1'b1;
							end else begin
								idv_d = 1'b0;
							end
						end
						kind_d = fsrp_pkg::KIND_IGNORED;
					end else if (!done_d) begin
						new_item = make_status(comm_d, cfg.sector_id_base,
							(rcrc_d == crc_d) ? fsrp_pkg::STATUS_OK
							: fsrp_pkg::STATUS_BAD_CRC);
						emit   = 1'b1;
						done_d = 1'b1;
						idv_d  = 1'b0;
					end
				end
			end
			if (pos_d != POS_MAX) begin
				pos_d = pos_d + fsrp_pkg::POS_W'(1);
			end
		end

		if (emit) begin
			if (n_d == 2'd0) begin
				item0_d = new_item;
			end else begin
				item1_d = new_item;
			end
			n_d = n_d + 2'd1;
		end

		if (end_s1 && open_d) begin
			if (kind_d == fsrp_pkg::KIND_DATA && !done_d) begin
				if (n_d == 2'd0) begin
					item0_d = make_status(comm_d, cfg.sector_id_base,
						fsrp_pkg::STATUS_TRUNCATED);
				end else begin
					item1_d = make_status(comm_d, cfg.sector_id_base,
						fsrp_pkg::STATUS_TRUNCATED);
				end
				n_d    = n_d + 2'd1;
				done_d = 1'b1;
				idv_d  = 1'b0;
			end
			open_d = 1'b0;
		end
	end

	assign push.cnt   = advance ? n_d : 2'd0;
	assign push.item0 = item0_d;
	assign push.item1 = item1_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			pos_q    <= '0;
			crc_q    <= fsrp_pkg::CFG_RESET.crc_seed;
			kind_q   <= fsrp_pkg::KIND_PENDING;
			done_q   <= 1'b0;
			rcrc_q   <= '0;
			shadow_q <= '0;
			comm_q   <= '0;
			idv_q    <= 1'b0;
		end else if (advance) begin
			open_q   <= open_d;
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			kind_q   <= kind_d;
			done_q   <= done_d;
			rcrc_q   <= rcrc_d;
			shadow_q <= shadow_d;
			comm_q   <= comm_d;
			idv_q    <= idv_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/floppy_sector_record_parser.sv @@
// Top level of the floppy sector record parser: configuration, parser and output queue.
`default_nettype none
`include "floppy_sector_record_parser_assert.svh"
// Parses decoded floppy record bytes into sector payload beats and one status beat per
// sector. Throughput is one input beat per clock cycle while the output queue has room;
// a byte is held in the input register and parsed combinationally, and its results are
// written into a four-entry output queue, from which they are presented. The input side
// stalls while that queue has fewer than two free entries, since one byte can give two
// results. Configuration must be written while no record is in progress.
module floppy_sector_record_parser #(
	parameter int MAX_SIZE_CODE = fsrp_pkg::MAX_SIZE_CODE_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // rec_byte
	input  wire         s_axis_tuser,  // record_start
	input  wire         s_axis_tlast,  // record_end
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // payload_byte, cylinder, head_side, sector_number,
	                                   // size_code, sector_status, two zero bits
	output logic        m_axis_tuser,  // item_kind
	output logic        m_axis_tlast,  // last_of_sector
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	fsrp_pkg::cfg_t  cfg_q;
	fsrp_pkg::push_t push;
	fsrp_pkg::item_t out_item;
	logic [fsrp_pkg::OUT_CNT_W-1:0] fifo_count;
	logic room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fsrp_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (fsrp_pkg::cfg_reg_t'(cfg_index))
				fsrp_pkg::CFG_HEADER_LEN:     cfg_q.header_len     <= cfg_data[1:0];
				fsrp_pkg::CFG_SECTOR_ID_BASE: cfg_q.sector_id_base <= cfg_data[7:0];
				fsrp_pkg::CFG_CRC_SEED:       cfg_q.crc_seed       <= cfg_data;
				fsrp_pkg::CFG_ID_MARK:        cfg_q.id_mark        <= cfg_data[7:0];
				fsrp_pkg::CFG_DATA_MARK_A:    cfg_q.data_mark_a    <= cfg_data[7:0];
				fsrp_pkg::CFG_DATA_MARK_B:    cfg_q.data_mark_b    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign room = (fifo_count <= fsrp_pkg::OUT_CNT_W'(fsrp_pkg::OUT_DEPTH - 2));

	fsrp_parser #(
		.MAX_SIZE_CODE(MAX_SIZE_CODE)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser),
		.in_end   (s_axis_tlast),
		.room     (room),
		.push     (push)
	);

	fsrp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.count     (fifo_count),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {2'b00, out_item.sector_status, out_item.size_code,
		out_item.sector_number, out_item.head_side, out_item.cylinder,
		out_item.payload_byte};
	assign m_axis_tuser = out_item.item_kind;
	assign m_axis_tlast = out_item.last_of_sector;

	`FSRP_ASSERT_IMP(a_queue_bound, 1'b1, fifo_count <= fsrp_pkg::OUT_CNT_W'(fsrp_pkg::OUT_DEPTH))
	`FSRP_ASSERT_IMP(a_push_needs_room, push.cnt != 2'd0, room)
	`FSRP_ASSERT_IMP(a_status_closes, m_axis_tvalid, m_axis_tuser == m_axis_tlast)
	`FSRP_ASSERT_NEXT(a_two_push_fill, push.cnt == 2'd2 && !m_axis_tready, fifo_count >= 3'd2)

endmodule
`default_nettype wire
